// ----- src/ikc_pkg.sv -----
// Package for the image kernel convolution unit.
// Holds shared constants, register indexes and controller/datapath command and status types.
package ikc_pkg;

  localparam int unsigned REG_ADDR_W = 6;

  localparam logic [2:0] REG_KROW0   = 3'd0;
  localparam logic [2:0] REG_KROW4   = 3'd4;
  localparam logic [2:0] REG_DIVISOR = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic        clear;     // reset the datapath position counters
    logic        write_pix; // store the input pixel and advance the input position
    logic        emit_load; // start gathering the window of the oldest pending pixel
    logic        win_step;  // fetch one window element
    logic        mac_step;  // accumulate one element
    logic        div_start; // start the quotient unit
    logic        finish;    // place the result in the output register
  } ikc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pix_item;      // the offered item is a pixel, not a drain
    logic emit_due;      // this pixel item causes a result
    logic drain_ok;      // a drain item causes a result
    logic interior;      // the pending pixel needs the kernel
    logic win_last;      // last window element is being fetched
    logic div_done;      // quotient unit finished
    logic out_free;      // output register can take a new result
  } ikc_sts_t;

endpackage

// ----- src/image_kernel_convolution_unit.sv -----
// Top level of the image kernel convolution unit: APB registers, controller, datapath.
// Depends on ikc_pkg, ikc_ctrl, ikc_datapath.
//
//  channel  | signals                         | payload
//  s_axis   | s_axis_tvalid/tready/tdata/tuser| tdata: red, green, blue; tuser: opcode
//  m_axis   | m_axis_tvalid/tready/tdata/tlast| tdata: red, green, blue; tlast: end_of_frame
//  apb      | psel/penable/pwrite/paddr/...   | eight registers at 8*i, 64-bit data
//
// A pixel item that emits nothing is stored without leaving idle. An item that
// emits a border pixel passes through the load and done states; an interior pixel
// also walks the window over the single line-store read port, then runs each
// channel through the bit-serial divider. Reset clears positions and restores
// register defaults. Input stalls while the output register holds an untaken result.
module image_kernel_convolution_unit import ikc_pkg::*; #(
  parameter int unsigned KERNEL_SIZE = 5,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned CHANNELS    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // red, green, blue
  input  logic                  s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // out_red, out_green, out_blue
  output logic                  m_axis_tlast,  // end_of_frame
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  logic [39:0] krow [5];
  logic [7:0]  divisor;
  logic [10:0] image_width, image_height;
  logic        wr_en, geom_write;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];
  assign geom_write = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) krow[i] <= '0;
      divisor      <= 8'd1;
      image_width  <= 11'd640;
      image_height <= 11'd480;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIVISOR: divisor      <= pwdata[7:0];
        REG_WIDTH:   image_width  <= pwdata[10:0];
        REG_HEIGHT:  image_height <= pwdata[10:0];
        default: begin
          if (reg_idx <= REG_KROW4) krow[reg_idx] <= pwdata[39:0];
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIVISOR: prdata = {56'd0, divisor};
      REG_WIDTH:   prdata = {53'd0, image_width};
      REG_HEIGHT:  prdata = {53'd0, image_height};
      default:     prdata = (reg_idx <= REG_KROW4) ? {24'd0, krow[reg_idx]} : 64'd0;
    endcase
  end

  ikc_cmd_t cmd;
  ikc_sts_t sts;

  ikc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst || geom_write),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ikc_datapath #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .CHANNELS    (CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (s_axis_tuser),
    .in_pixel     (CHANNELS > 1 ? s_axis_tdata : {16'd0, s_axis_tdata[7:0]}),
    .krow         (krow),
    .divisor      (divisor),
    .image_width  (image_width),
    .image_height (image_height),
    .geom_write   (geom_write),
    .out_take     (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_pixel    (m_axis_tdata),
    .out_eof      (m_axis_tlast)
  );

endmodule

// ----- src/ikc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ikc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ikc_div.sv -----
// Iterative signed division, truncating toward zero, one quotient bit per cycle.
// Outputs the quotient magnitude; no dependencies; used by the datapath.
module ikc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [7:0]         divisor,
  output logic               done,
  output logic [31:0]        mag_quot
);

  logic [31:0] rem_q;
  logic [31:0] num;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem_q, num[31]} - {25'd0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The magnitude of the quotient is the quotient of magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      num   <= dividend[31] ? 32'(-dividend) : 32'(dividend);
    end else if (busy) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        num   <= {num[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], num[31]};
        num   <= {num[30:0], 1'b0};
      end
    end
  end

  assign mag_quot = num;

endmodule

// ----- src/ikc_datapath.sv -----
// Datapath: line store, position counters, window gather, multiply-accumulate, division.
// Depends on ikc_pkg, ikc_ram and ikc_div.
module ikc_datapath import ikc_pkg::*; #(
  parameter int unsigned KERNEL_SIZE = 5,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned CHANNELS    = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  ikc_cmd_t     cmd,
  output ikc_sts_t     sts,
  input  logic         in_opcode,
  input  logic [23:0]  in_pixel,
  input  logic [39:0]  krow [5],
  input  logic [7:0]   divisor,
  input  logic [10:0]  image_width,
  input  logic [10:0]  image_height,
  input  logic         geom_write,
  input  logic         out_take,
  output logic         out_valid,
  output logic [23:0]  out_pixel,
  output logic         out_eof
);

  localparam int unsigned HALF   = KERNEL_SIZE / 2;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W = $clog2(KERNEL_SIZE);
  localparam int unsigned ADDR_W = $clog2(KERNEL_SIZE * MAX_WIDTH);
  localparam int unsigned NWIN   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned WIN_W  = $clog2(NWIN + 1);
  localparam int unsigned CH_N   = (CHANNELS > 3) ? 3 : CHANNELS;
  // Channels beyond the build's channel count always read as zero.
  localparam logic [23:0] CH_MASK = (CH_N < 2) ? 24'h0000ff :
                                    ((CH_N < 3) ? 24'h00ffff : 24'hffffff);

  // Effective geometry.
  logic [COL_W:0] w_eff;
  logic [10:0]    h_eff;
  always_comb begin
    if (image_width == 11'd0)                  w_eff = (COL_W+1)'(1);
    else if (32'(image_width) > MAX_WIDTH)     w_eff = (COL_W+1)'(MAX_WIDTH);
    else                                       w_eff = (COL_W+1)'(image_width);
    if (image_height == 11'd0)                 h_eff = 11'd1;
    else if (image_height > 11'd1024)          h_eff = 11'd1024;
    else                                       h_eff = image_height;
  end

  logic [COL_W-1:0]  in_col, out_col;
  logic [10:0]       in_row, out_row;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [23:0]       pending;
  logic [23:0]       lag;

  assign lag = 24'(HALF) * 24'(w_eff) + 24'(HALF);

  assign sts.pix_item = (in_opcode == OP_PIXEL);
  assign sts.emit_due = (in_opcode == OP_PIXEL) && ((pending + 24'd1) > lag);
  assign sts.drain_ok = (in_opcode == OP_DRAIN) && (in_col == '0) && (in_row == '0)
                        && (pending != '0);

  logic interior;
  assign interior = (32'(out_row) >= HALF) && (32'(out_row) + HALF < 32'(h_eff))
                 && (32'(out_col) >= HALF) && (32'(out_col) + HALF < 32'(w_eff));
  assign sts.interior = interior;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (32'(s) == KERNEL_SIZE - 1) ? '0 : s + SLOT_W'(1);
  endfunction

  // Window walker: row z and column u of the element fetched this cycle.
  logic [SLOT_W-1:0] wz_slot;
  logic [SLOT_W-1:0] wz, wu;
  logic [COL_W-1:0]  wcol;
  logic [WIN_W-1:0]  widx;
  logic              rd_valid;
  logic [SLOT_W-1:0] rd_z, rd_u;

  assign sts.win_last = (32'(wz) == KERNEL_SIZE - 1) && (32'(wu) == KERNEL_SIZE - 1);

  // Line store addressing.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [23:0]       ram_rdata;

  assign ram_we    = cmd.write_pix;
  assign ram_waddr = ADDR_W'(32'(in_slot) * MAX_WIDTH + 32'(in_col));
  assign ram_raddr = cmd.win_step
                     ? ADDR_W'(32'(wz_slot) * MAX_WIDTH + 32'(wcol))
                     : ADDR_W'(32'(out_slot) * MAX_WIDTH + 32'(out_col));

  ikc_ram #(.WIDTH(24), .DEPTH(KERNEL_SIZE * MAX_WIDTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_pixel),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || geom_write || cmd.clear) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      pending  <= '0;
    end else begin
      if (cmd.write_pix) begin
        if (32'(in_col) + 1 >= 32'(w_eff)) begin
          in_col  <= '0;
          in_slot <= slot_inc(in_slot);
          in_row  <= (in_row + 11'd1 >= h_eff) ? 11'd0 : in_row + 11'd1;
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      case ({cmd.write_pix, cmd.finish})
        2'b10:   pending <= pending + 24'd1;
        2'b01:   pending <= pending - 24'd1;
        default: pending <= pending;
      endcase
    end
  end

  // Window walk and accumulation.
  logic signed [31:0] acc [3];
  logic signed [7:0]  cf;
  logic               emit_int;
  logic [COL_W-1:0]   base_col;

  always_comb begin
    cf = $signed(krow[rd_z][8*rd_u +: 8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.win_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      wz       <= '0;
      wu       <= '0;
      wz_slot  <= SLOT_W'((32'(out_slot) + KERNEL_SIZE - HALF) % KERNEL_SIZE);
      base_col <= out_col - COL_W'(HALF);
      wcol     <= out_col - COL_W'(HALF);
      widx     <= '0;
      emit_int <= interior;
    end else if (cmd.win_step) begin
      rd_z <= wz;
      rd_u <= wu;
      widx <= widx + WIN_W'(1);
      if (32'(wu) == KERNEL_SIZE - 1) begin
        wu      <= '0;
        wz      <= wz + SLOT_W'(1);
        wz_slot <= slot_inc(wz_slot);
        wcol    <= base_col;
      end else begin
        wu   <= wu + SLOT_W'(1);
        wcol <= wcol + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      for (int c = 0; c < 3; c++) acc[c] <= '0;
    end else if (rd_valid) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] + $signed({24'd0, ram_rdata[8*c +: 8]}) * 32'(cf);
      end
    end
  end

  // Channels go through the divider one after another.
  logic [1:0]  div_ch;
  logic        div_go;
  logic        div_done;
  logic [31:0] div_q;
  logic [7:0]  dv;
  logic [23:0] res;

  assign dv = (divisor == 8'd0) ? 8'd1 : divisor;
  assign div_go = cmd.div_start || (div_done && 32'(div_ch) + 1 < CH_N);
  assign sts.div_done = div_done && (32'(div_ch) + 1 >= CH_N);

  ikc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (acc[cmd.div_start ? 2'd0 : div_ch + 2'd1]),
    .divisor  (dv),
    .done     (div_done),
    .mag_quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_ch <= '0;
      res    <= '0;
    end else if (div_done) begin
      res[8*div_ch +: 8] <= div_q[7:0];
      div_ch <= div_ch + 2'd1;
    end
  end

  // Output register and output position.
  logic eof;
  assign eof = (out_row + 11'd1 == h_eff) && (32'(out_col) + 1 == 32'(w_eff));
  assign sts.out_free = !out_valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_eof   <= eof;
      out_pixel <= (emit_int ? res : ram_rdata) & CH_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_write || cmd.clear) begin
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else if (cmd.finish) begin
      if (32'(out_col) + 1 >= 32'(w_eff)) begin
        out_col  <= '0;
        out_slot <= slot_inc(out_slot);
        out_row  <= (out_row + 11'd1 >= h_eff) ? 11'd0 : out_row + 11'd1;
      end else begin
        out_col <= out_col + COL_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> out_valid)
    else $error("finish did not load the output register");
  assert property (@(posedge clk) disable iff (rst) !(cmd.write_pix && cmd.win_step))
    else $error("store write during window walk");
  assert property (@(posedge clk) disable iff (rst) 32'(widx) <= NWIN)
    else $error("window index ran past the window");

endmodule

// ----- src/ikc_ctrl.sv -----
// Controller state machine: sequences pixel writes, window walks and division.
// Depends on ikc_pkg.
module ikc_ctrl import ikc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ikc_sts_t sts,
  output ikc_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_WALK = 6'b000100,
    S_TAIL = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   acc_due;
  logic   tail_cnt, tail_cnt_next;

  assign in_ready = (state == S_IDLE) && sts.out_free;
  assign acc_due  = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    tail_cnt_next = tail_cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (acc_due) begin
          // Pixel items are always stored; drain items never are.
          cmd.write_pix = sts.pix_item;
          if (sts.emit_due || sts.drain_ok) begin
            cmd.emit_load = 1'b1;
            state_next    = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (sts.interior) begin
          cmd.win_step = 1'b1;
          state_next   = S_WALK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        cmd.win_step = 1'b1;
        if (sts.win_last) begin
          state_next    = S_TAIL;
          tail_cnt_next = 1'b0;
        end
      end
      S_TAIL: begin
        tail_cnt_next = 1'b1;
        if (tail_cnt) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tail_cnt <= 1'b0;
    end else begin
      state    <= state_next;
      tail_cnt <= tail_cnt_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> state == S_IDLE)
    else $error("finish not followed by idle");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> state == S_DIV)
    else $error("division start lost");

endmodule
